// ----- design/first_free_handle_table_unit_defines.svh -----
// Assertion macros for the first-free handle table unit.
// Used by the top level; depends on nothing else.
`ifndef FIRST_FREE_HANDLE_TABLE_UNIT_DEFINES_SVH
`define FIRST_FREE_HANDLE_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Plain property checked on every rising clock edge outside reset.
`define FFHT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication checked outside reset.
`define FFHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define FFHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FFHT_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FFHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/ffht_pkg.sv -----
// Shared types and constants of the first-free handle table unit.
// Depends on nothing; used by every module of the block but ffht_ram.
package ffht_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ENTRY_WIDTH_DEF = 32;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_GET     = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;
	localparam logic [1:0] ACT_QUERY   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  slot_number;
		logic [31:0] object_word;
	} ffht_req_t;

	typedef struct packed {
		logic [3:0]  granted_slot;
		logic [31:0] read_word;
		logic [1:0]  status;
		logic        table_empty;
	} ffht_rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic load_rsp;
	} ffht_cmd_t;

endpackage

// ----- design/first_free_handle_table_unit.sv -----
// First-free handle table. The table holds TABLE_DEPTH entries of ENTRY_WIDTH
// bits, and an entry of zero is a free slot. An alloc beat stores its object
// word in the lowest free slot and returns that slot (status full when no slot
// is free); a get beat returns the word of a slot; a release beat frees a slot;
// a query beat only reports emptiness. Every result beat says whether the table
// is empty after the request. In the cycle a request is accepted the occupancy
// bits are searched and updated and the entry RAM is written or read, and in the
// next cycle the registered RAM read data completes the result, which is then
// loaded into the output register once that register is free. A new request is
// accepted only after the previous result has been loaded into the output
// register, even while that result still sits there; the new result then waits
// until that one is taken. Occupancy is kept in flip-flops cleared by reset, so
// the table is usable right after reset with no clearing pass. Reset is
// asynchronous, active low.
`include "first_free_handle_table_unit_defines.svh"

module first_free_handle_table_unit #(
	parameter int TABLE_DEPTH = ffht_pkg::TABLE_DEPTH_DEF,
	parameter int ENTRY_WIDTH = ffht_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ffht_pkg::ffht_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ffht_pkg::ffht_rsp_t rsp
);

	ffht_pkg::ffht_cmd_t cmd;

	// The controller sequences each request and owns the result valid flag.
	ffht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd)
	);

	// The datapath holds the table, the occupancy bits and the output register.
	ffht_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ENTRY_WIDTH(ENTRY_WIDTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.rsp   (rsp)
	);

	// A request is followed by a cycle in which no new request is taken.
	`FFHT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready,
		"request accepted while the previous one is still in progress")
	// A full table can never be empty.
	`FFHT_ASSERT_IMP(a_full_not_empty, clk, arst_n,
		rsp_valid && (rsp.status == ffht_pkg::ST_FULL), !rsp.table_empty,
		"table reported full and empty at once")
	// Only a successful request can grant a slot.
	`FFHT_ASSERT_IMP(a_grant_on_ok, clk, arst_n,
		rsp_valid && (rsp.status != ffht_pkg::ST_OK), rsp.granted_slot == 4'd0,
		"slot granted on a failed request")
	// An out-of-range slot never returns data.
	`FFHT_ASSERT_IMP(a_range_no_data, clk, arst_n,
		rsp_valid && (rsp.status == ffht_pkg::ST_RANGE), rsp.read_word == 32'd0,
		"data returned for an out-of-range slot")

endmodule

// ----- design/ffht_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ffht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/ffht_ctrl.sv -----
// Controller of the handle table: request/result sequencing and result valid.
// Depends on ffht_pkg.
module ffht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ffht_pkg::ffht_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RESP = 1'b1;

	logic state_q;
	logic rsp_valid_q;
	logic accept;
	logic load_rsp;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	// The result moves to the output register once that register is free.
	assign load_rsp  = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign cmd.accept   = accept;
	assign cmd.load_rsp = load_rsp;

endmodule

// ----- design/ffht_dp.sv -----
// Datapath of the handle table: occupancy bits, first-free search, entry RAM,
// request result registers and the output register. Depends on ffht_pkg, ffht_ram.
module ffht_dp #(
	parameter int TABLE_DEPTH = ffht_pkg::TABLE_DEPTH_DEF,
	parameter int ENTRY_WIDTH = ffht_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffht_pkg::ffht_cmd_t cmd,
	input  ffht_pkg::ffht_req_t req,
	output ffht_pkg::ffht_rsp_t rsp
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [TABLE_DEPTH-1:0] occ_q;
	logic [TABLE_DEPTH-1:0] occ_d;
	logic [IDX_W-1:0]       free_idx;
	logic                   any_free;
	logic [IDX_W-1:0]       slot_idx;
	logic                   slot_in_range;
	logic                   slot_used;
	logic [ENTRY_WIDTH-1:0] word;
	logic                   ram_we;
	logic                   ram_re;
	logic [ENTRY_WIDTH-1:0] ram_rdata;
	logic [3:0]             granted_d;
	logic [1:0]             status_d;

	logic [3:0]             granted_q;
	logic [1:0]             status_q;
	logic                   empty_q;
	logic                   rd_sel_q;
	ffht_pkg::ffht_rsp_t    rsp_q;

	// Lowest free slot: priority encoder over the occupancy bits.
	always_comb begin
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign any_free      = ~&occ_q;
	assign slot_idx      = req.slot_number[IDX_W-1:0];
	assign slot_in_range = ({1'b0, req.slot_number} < 9'(TABLE_DEPTH));
	assign slot_used     = slot_in_range && occ_q[slot_idx];
	assign word          = ENTRY_WIDTH'(req.object_word);

	always_comb begin
		occ_d     = occ_q;
		granted_d = '0;
		status_d  = ffht_pkg::ST_OK;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		case (req.action)
			ffht_pkg::ACT_ALLOC: begin
				if (any_free) begin
					occ_d[free_idx] = |word;
					granted_d       = 4'(free_idx);
					ram_we          = cmd.accept;
				end else begin
					status_d = ffht_pkg::ST_FULL;
				end
			end
			ffht_pkg::ACT_GET: begin
				ram_re = cmd.accept && slot_used;
				if (!slot_in_range) begin
					status_d = ffht_pkg::ST_RANGE;
				end
			end
			ffht_pkg::ACT_RELEASE: begin
				if (!slot_in_range) begin
					status_d = ffht_pkg::ST_RANGE;
				end else if (!slot_used) begin
					status_d = ffht_pkg::ST_EMPTY;
				end else begin
					occ_d[slot_idx] = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	ffht_ram #(
		.WIDTH(ENTRY_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx),
		.wdata(word),
		.re   (ram_re),
		.raddr(slot_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.accept) begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			granted_q <= granted_d;
			status_q  <= status_d;
			empty_q   <= ~|occ_d;
			rd_sel_q  <= (req.action == ffht_pkg::ACT_GET) && slot_used;
		end
		if (cmd.load_rsp) begin
			rsp_q.granted_slot <= granted_q;
			rsp_q.read_word    <= rd_sel_q ? 32'(ram_rdata) : 32'd0;
			rsp_q.status       <= status_q;
			rsp_q.table_empty  <= empty_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for first_free_handle_table_unit.
// Depends on ffht_pkg and the RTL only; a scoreboard class predicts every
// response beat; tasks drive requests, an always block drives rsp_ready.
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH         = ffht_pkg::TABLE_DEPTH_DEF;
	localparam int ENTRY_W       = ffht_pkg::ENTRY_WIDTH_DEF;
	localparam int SLOT_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RANDOM_ITEMS  = 2000;
	// The slowest correct run is far below this figure, even with about 2000
	// beats, sender gaps between bursts and long receiver stalls.
	localparam int CYCLE_LIMIT   = 600000;
	// The unit holds at most one request in flight and one result in its
	// output register.
	localparam int TAIL_CYCLES   = 10;
	localparam int REPORT_LIMIT  = 10;

	// Tracks the contents of the handle table and the response beats that
	// are still owed by the unit, oldest first.
	class handle_tracker;
		logic [ENTRY_W-1:0]  slot_words[DEPTH];
		ffht_pkg::ffht_rsp_t owed_responses[$];
		int                  mismatches;

		function new();
			for (int i = 0; i < DEPTH; i++) slot_words[i] = '0;
			mismatches = 0;
		endfunction

		// Applies one accepted request to the tracked table and queues the
		// response the unit must return for it.
		function void note_request(ffht_pkg::ffht_req_t r);
			ffht_pkg::ffht_rsp_t p;
			logic [ENTRY_W-1:0]  w;
			bit                  found;
			p = '0;
			w = ENTRY_W'(r.object_word);
			found = 1'b0;
			case (r.action)
				ffht_pkg::ACT_ALLOC: begin
					// First fit: the lowest zero entry wins. A zero word is
					// still granted but leaves the slot free.
					p.status = ffht_pkg::ST_FULL;
					for (int i = 0; i < DEPTH; i++) begin
						if (!found && slot_words[i] == '0) begin
							slot_words[i] = w;
							p.granted_slot = 4'(i);
							p.status = ffht_pkg::ST_OK;
							found = 1'b1;
						end
					end
				end
				ffht_pkg::ACT_GET: begin
					if (r.slot_number < DEPTH)
						p.read_word = 32'(slot_words[r.slot_number[SLOT_W-1:0]]);
					else
						p.status = ffht_pkg::ST_RANGE;
				end
				ffht_pkg::ACT_RELEASE: begin
					if (r.slot_number >= DEPTH)
						p.status = ffht_pkg::ST_RANGE;
					else if (slot_words[r.slot_number[SLOT_W-1:0]] == '0)
						p.status = ffht_pkg::ST_EMPTY;
					else
						slot_words[r.slot_number[SLOT_W-1:0]] = '0;
				end
				default: ;
			endcase
			p.table_empty = 1'b1;
			for (int i = 0; i < DEPTH; i++)
				if (slot_words[i] != '0) p.table_empty = 1'b0;
			owed_responses.push_back(p);
		endfunction

		// Compares one accepted response beat with the oldest owed one.
		function void check_response(ffht_pkg::ffht_rsp_t got);
			ffht_pkg::ffht_rsp_t want;
			if (owed_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected response beat: slot=%0d word=%h st=%0d empty=%0b",
						got.granted_slot, got.read_word, got.status, got.table_empty);
				return;
			end
			want = owed_responses.pop_front();
			if (got.granted_slot !== want.granted_slot || got.read_word !== want.read_word
					|| got.status !== want.status || got.table_empty !== want.table_empty) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$write("response mismatch: exp slot=%0d word=%h st=%0d empty=%0b, ",
						want.granted_slot, want.read_word, want.status, want.table_empty);
					$display("got slot=%0d word=%h st=%0d empty=%0b",
						got.granted_slot, got.read_word, got.status, got.table_empty);
				end
			end
		endfunction

		function int owed();
			return owed_responses.size();
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	ffht_pkg::ffht_req_t req       = '0;
	logic                rsp_ready = 1'b0;
	logic                req_ready;
	logic                rsp_valid;
	ffht_pkg::ffht_rsp_t rsp;

	handle_tracker tracker = new();
	int            cycles  = 0;

	// Receiver pattern state: the current stall mode, how long it lasts, and
	// the remaining length of a long stall.
	int rx_mode  = 0;
	int rx_left  = 0;
	int rx_stall = 0;

	first_free_handle_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Global watchdog. A hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Response side. Beats are checked as they are accepted, and rsp_ready
	// follows a pattern of its own: stretches of always-ready, random
	// ready, long stalls, and a toggling ready. Each mode lasts a
	// random number of cycles so that stalls land on every phase of the
	// unit's request flow.
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			tracker.check_response(rsp);
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 9) < 7);
			2: begin
				if (rx_stall > 0) begin
					rsp_ready <= 1'b0;
					rx_stall--;
				end else begin
					rsp_ready <= 1'b1;
					if ($urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 16);
				end
			end
			default: rsp_ready <= ~rsp_ready;
		endcase
	end

	// Presents one request beat and returns at the edge where it is taken.
	// Called at a rising edge; valid stays high with the payload held until
	// the handshake.
	task automatic send_beat(input ffht_pkg::ffht_req_t r);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		tracker.note_request(r);
	endtask

	task automatic send_fields(input logic [1:0] a, input logic [7:0] s, input logic [31:0] w);
		ffht_pkg::ffht_req_t r;
		r.action      = a;
		r.slot_number = s;
		r.object_word = w;
		send_beat(r);
	endtask

	// Drops valid for a pause set by n, and does nothing when n is zero; the
	// payload wanders meanwhile, since the unit must ignore it.
	task automatic pause(input int n);
		ffht_pkg::ffht_req_t junk;
		if (n > 0) begin
			junk.action      = 2'($urandom);
			junk.slot_number = 8'($urandom);
			junk.object_word = $urandom;
			req_valid <= 1'b0;
			req       <= junk;
			repeat (n) @(posedge clk);
		end
	endtask

	// Holds the sender off until every owed response beat has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (tracker.owed() != 0) @(posedge clk);
	endtask

	// Object words lean toward the corners: zero (which leaves the slot
	// free), all ones and single set bits, with plain random words otherwise.
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 19))
			0:       return 32'h0;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	// Builds one random request. The weights steer the table toward full or
	// toward empty; releases and gets mostly name a slot in use so that the
	// table really drains, with some free and out-of-range slots as noise.
	function automatic ffht_pkg::ffht_req_t random_request(input int alloc_pct,
			input int release_pct);
		ffht_pkg::ffht_req_t r;
		int                  roll;
		int                  start;
		int                  idx;
		r.object_word = random_word();
		r.slot_number = 8'($urandom_range(0, DEPTH - 1));
		roll = $urandom_range(0, 99);
		if (roll < alloc_pct)
			r.action = ffht_pkg::ACT_ALLOC;
		else if (roll < alloc_pct + release_pct)
			r.action = ffht_pkg::ACT_RELEASE;
		else if (roll < 92)
			r.action = ffht_pkg::ACT_GET;
		else
			r.action = ffht_pkg::ACT_QUERY;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			r.slot_number = 8'($urandom_range(DEPTH, 255));
		end else if (roll < 75) begin
			start = $urandom_range(0, DEPTH - 1);
			for (int k = 0; k < DEPTH; k++) begin
				idx = (start + k) % DEPTH;
				if (tracker.slot_words[idx] != '0) begin
					r.slot_number = 8'(idx);
					break;
				end
			end
		end
		return r;
	endfunction

	initial begin
		ffht_pkg::ffht_req_t r;
		int                  sent;
		int                  burst;
		int                  alloc_pct;
		int                  release_pct;
		bit                  pressured;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The table starts empty: query, gets of the first
		// and last slot and just past the end, and releases of a free slot
		// and of the highest index.
		send_fields(ffht_pkg::ACT_QUERY,   8'd0,   32'h0);
		send_fields(ffht_pkg::ACT_GET,     8'd0,   32'hFFFF_FFFF);
		send_fields(ffht_pkg::ACT_GET,     8'(DEPTH - 1), 32'h0);
		send_fields(ffht_pkg::ACT_GET,     8'(DEPTH), 32'h0);
		send_fields(ffht_pkg::ACT_GET,     8'd255, 32'h0);
		pause(1);
		send_fields(ffht_pkg::ACT_RELEASE, 8'd0,   32'h0);
		send_fields(ffht_pkg::ACT_RELEASE, 8'd255, 32'hFFFF_FFFF);
		// A zero word is granted slot zero but the table stays empty.
		send_fields(ffht_pkg::ACT_ALLOC,   8'd0,   32'h0);
		send_fields(ffht_pkg::ACT_ALLOC,   8'd255, 32'hFFFF_FFFF);
		pause(2);
		// Fill the rest of the table, then try one more alloc on a full
		// table, read back the top slot, and free a slot in the middle so
		// that first fit must pick it.
		for (int i = 1; i < DEPTH; i++) begin
			send_fields(ffht_pkg::ACT_ALLOC, 8'($urandom), 32'h1 << (i % 32));
			pause($urandom_range(0, 1));
		end
		send_fields(ffht_pkg::ACT_ALLOC,   8'd0,   32'hA5A5_5A5A);
		send_fields(ffht_pkg::ACT_GET,     8'(DEPTH - 1), 32'h0);
		send_fields(ffht_pkg::ACT_RELEASE, 8'(DEPTH / 2), 32'h0);
		send_fields(ffht_pkg::ACT_RELEASE, 8'(DEPTH / 2), 32'h0);
		send_fields(ffht_pkg::ACT_ALLOC,   8'd0,   32'h8000_0001);
		send_fields(ffht_pkg::ACT_QUERY,   8'hFF,  32'hFFFF_FFFF);
		wait_drained();

		// Random part, in phases that fill, drain or churn the table. The
		// sender works in bursts, some with no gap at all after them.
		sent = 0;
		pressured = 1'b0;
		alloc_pct = 40;
		release_pct = 35;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 150 < 40 && $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 2))
					0:       begin alloc_pct = 70; release_pct = 15; end
					1:       begin alloc_pct = 15; release_pct = 70; end
					default: begin alloc_pct = 40; release_pct = 35; end
				endcase
			end
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				r = random_request(alloc_pct, release_pct);
				send_beat(r);
				sent++;
			end
			// Halfway through, let the unit drain completely before going on.
			if (!pressured && sent >= RANDOM_ITEMS / 2) begin
				wait_drained();
				pressured = 1'b1;
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 12));
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.owed() != 0)
			$display("response beats never returned: %0d", tracker.owed());
		if (tracker.mismatches == 0 && tracker.owed() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/ffht_pkg.sv
design/ffht_ram.sv
design/ffht_ctrl.sv
design/ffht_dp.sv
design/first_free_handle_table_unit.sv
dv/testbench.sv
